[sv/pvhe_pkg.sv]
// pvhe_pkg: shared types and marker constants for the value and header encoder
// used by pvhe_encode and packstream_value_header_encoder_core
// no dependencies
package pvhe_pkg;

	// request kind codes
	localparam logic [3:0] FN_NULL   = 4'd0;
	localparam logic [3:0] FN_BOOL   = 4'd1;
	localparam logic [3:0] FN_INT    = 4'd2;
	localparam logic [3:0] FN_FLOAT  = 4'd3;
	localparam logic [3:0] FN_STRING = 4'd4;
	localparam logic [3:0] FN_BYTES  = 4'd5;
	localparam logic [3:0] FN_LIST   = 4'd6;
	localparam logic [3:0] FN_MAP    = 4'd7;
	localparam logic [3:0] FN_STRUCT = 4'd8;

	// marker bytes
	localparam logic [7:0] MK_NULL   = 8'hC0;
	localparam logic [7:0] MK_FLOAT  = 8'hC1;
	localparam logic [7:0] MK_FALSE  = 8'hC2;
	localparam logic [7:0] MK_TRUE   = 8'hC3;
	localparam logic [7:0] MK_INT8   = 8'hC8;
	localparam logic [7:0] MK_INT16  = 8'hC9;
	localparam logic [7:0] MK_INT32  = 8'hCA;
	localparam logic [7:0] MK_INT64  = 8'hCB;
	localparam logic [7:0] MK_BYTES8 = 8'hCC;
	localparam logic [7:0] MK_STR8   = 8'hD0;
	localparam logic [7:0] MK_LIST8  = 8'hD4;
	localparam logic [7:0] MK_MAP8   = 8'hD8;
	localparam logic [7:0] MK_STR_T  = 8'h80;
	localparam logic [7:0] MK_LIST_T = 8'h90;
	localparam logic [7:0] MK_MAP_T  = 8'hA0;
	localparam logic [7:0] MK_STRUCT = 8'hB0;

	// longest encoding in bytes
	localparam int MaxBytes = 9;
	localparam int BufW     = MaxBytes * 8;
	localparam int CntW     = 4;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [63:0] value;
		logic signed [31:0] length;
		logic signed [15:0] struct_tag;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} res_t;

	// encoded bytes, left aligned, first byte in the top bits
	typedef struct packed {
		logic [BufW-1:0] bytes;
		logic [CntW-1:0] count;
		logic            error;
	} enc_t;

endpackage

[sv/pvhe_encode.sv]
// pvhe_encode: combinational encoder from one request to its byte string
// depends on pvhe_pkg
module pvhe_encode (
	input  pvhe_pkg::req_t req,
	output pvhe_pkg::enc_t enc
);
	import pvhe_pkg::*;

	// length header: tiny form when has_tiny, else 8, 16 or 32-bit length
	function automatic enc_t put_header(input logic [31:0] len, input logic has_tiny,
		input logic [7:0] tiny_base, input logic [7:0] m8);
		enc_t e;
		e = '0;
		if (has_tiny && len < 32'h10) begin
			e.bytes = {tiny_base | {4'h0, len[3:0]}, 64'h0};
			e.count = CntW'(1);
		end else if (len < 32'h100) begin
			e.bytes = {m8, len[7:0], 56'h0};
			e.count = CntW'(2);
		end else if (len < 32'h10000) begin
			e.bytes = {m8 + 8'd1, len[15:0], 48'h0};
			e.count = CntW'(3);
		end else begin
			e.bytes = {m8 + 8'd2, len, 32'h0};
			e.count = CntW'(5);
		end
		return e;
	endfunction

	logic [63:0] v;
	logic [31:0] len;
	logic        len_neg;
	logic        fits8;
	logic        fits16;
	logic        fits32;
	logic        tiny_int;
	enc_t        err_enc;

	assign v        = req.value;
	assign len      = req.length;
	assign len_neg  = len[31];

	// sign-extension checks for the shortest integer form
	assign fits8    = (v[63:7] == '0) || (v[63:7] == '1);
	assign fits16   = (v[63:15] == '0) || (v[63:15] == '1);
	assign fits32   = (v[63:31] == '0) || (v[63:31] == '1);
	assign tiny_int = fits8 && (!v[7] || v[7:4] == 4'hF);

	assign err_enc  = '{bytes: '0, count: CntW'(1), error: 1'b1};

	// select encoding by kind
	always_comb begin
		enc = err_enc;
		case (req.func)
			FN_NULL: begin
				enc = '{bytes: {MK_NULL, 64'h0}, count: CntW'(1), error: 1'b0};
			end
			FN_BOOL: begin
				enc = '{bytes: {(v != '0) ? MK_TRUE : MK_FALSE, 64'h0},
					count: CntW'(1), error: 1'b0};
			end
			FN_INT: begin
				if (tiny_int) begin
					enc = '{bytes: {v[7:0], 64'h0}, count: CntW'(1), error: 1'b0};
				end else if (fits8) begin
					enc = '{bytes: {MK_INT8, v[7:0], 56'h0}, count: CntW'(2), error: 1'b0};
				end else if (fits16) begin
					enc = '{bytes: {MK_INT16, v[15:0], 48'h0}, count: CntW'(3), error: 1'b0};
				end else if (fits32) begin
					enc = '{bytes: {MK_INT32, v[31:0], 32'h0}, count: CntW'(5), error: 1'b0};
				end else begin
					enc = '{bytes: {MK_INT64, v}, count: CntW'(9), error: 1'b0};
				end
			end
			FN_FLOAT: begin
				enc = '{bytes: {MK_FLOAT, v}, count: CntW'(9), error: 1'b0};
			end
			FN_STRING: begin
				if (!len_neg) enc = put_header(len, 1'b1, MK_STR_T, MK_STR8);
			end
			FN_BYTES: begin
				if (!len_neg) enc = put_header(len, 1'b0, 8'h00, MK_BYTES8);
			end
			FN_LIST: begin
				if (!len_neg) enc = put_header(len, 1'b1, MK_LIST_T, MK_LIST8);
			end
			FN_MAP: begin
				if (!len_neg) enc = put_header(len, 1'b1, MK_MAP_T, MK_MAP8);
			end
			FN_STRUCT: begin
				if (!len_neg && len < 32'h10 && !req.struct_tag[15]) begin
					enc = '{bytes: {MK_STRUCT | {4'h0, len[3:0]}, req.struct_tag[7:0], 56'h0},
						count: CntW'(2), error: 1'b0};
				end
			end
			default: begin
				enc = err_enc;
			end
		endcase
	end

endmodule

[sv/packstream_value_header_encoder_core.sv]
// packstream_value_header_encoder_core: top level of the value and header encoder
// depends on pvhe_pkg and pvhe_encode
//
// Usage:
//   The req channel takes one request per item (kind, value, length, tag).
//   The res channel gives the encoding one byte per item, first byte first;
//   last marks the final byte, and an invalid request gives a single item
//   with error and last set and a zero byte.
//   A request is registered in stage 1, encoded by combinational logic and
//   loaded into the stage 2 byte shifter, which drives res directly.
//   The first byte is shown once the request passes the stage 1 register
//   and is loaded into the stage 2 shifter. Throughput: with res_stall low,
//   one request per cycle for one-byte encodings; an encoding of up to 9
//   bytes holds the shifter until its last byte is taken, at one byte per cycle.
//   Stage 1 takes the next request while stage 2 still sends bytes, and it
//   moves on in the cycle the last byte of the previous encoding is taken.
//   When res_stall is high the shown byte holds; req_stall rises while stage
//   1 is full, stage 2 holds bytes and its last byte is not being taken.
//   Reset empties both stages; no item is shown until a request arrives.
module packstream_value_header_encoder_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pvhe_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output pvhe_pkg::res_t res
);
	import pvhe_pkg::*;

	logic            vld_s1;
	req_t            req_s1;
	logic            vld_s2;
	logic [BufW-1:0] bytes_s2;
	logic [CntW-1:0] cnt_s2;
	logic            err_s2;
	enc_t            enc;
	logic            s2_take;
	logic            s2_last;
	logic            s2_free;
	logic            s1_move;
	logic            req_take;

	pvhe_encode u_encode (
		.req (req_s1),
		.enc (enc)
	);

	// handshake between the stages
	assign s2_last   = (cnt_s2 == CntW'(1));
	assign s2_take   = vld_s2 && !res_stall;
	assign s2_free   = !vld_s2 || (s2_take && s2_last);
	assign s1_move   = vld_s1 && s2_free;
	assign req_stall = vld_s1 && !s2_free;
	assign req_take  = req_valid && !req_stall;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_take) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage 1 request register
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_s1 <= req;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_move) begin
			vld_s2 <= 1'b1;
		end else if (s2_take && s2_last) begin
			vld_s2 <= 1'b0;
		end
	end

	// stage 2 byte shifter and remaining count
	always_ff @(posedge clk) begin
		if (s1_move) begin
			bytes_s2 <= enc.bytes;
			cnt_s2   <= enc.count;
			err_s2   <= enc.error;
		end else if (s2_take) begin
			bytes_s2 <= {bytes_s2[BufW-9:0], 8'h00};
			cnt_s2   <= cnt_s2 - CntW'(1);
		end
	end

	// result item
	assign res_valid    = vld_s2;
	assign res.out_byte = bytes_s2[BufW-1 -: 8];
	assign res.last     = s2_last;
	assign res.error    = err_s2;

`ifndef SYNTH
	// a shown item always has bytes left to send
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (cnt_s2 != '0 && cnt_s2 <= CntW'(MaxBytes)))
		else $error("stage 2 count out of range");

	// an error encoding is a single item
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && err_s2) |-> s2_last)
		else $error("error item is not last");

	// requests are only held off while stage 1 is occupied
	a_stall_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> vld_s1)
		else $error("stall with empty stage 1");

	// a moved request lands in stage 2 with its full byte count
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> (vld_s2 && cnt_s2 == $past(enc.count)))
		else $error("stage 2 load lost");

	// a stalled byte shifter keeps its count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_stall) |=> $stable(cnt_s2))
		else $error("count changed while stalled");
`endif

endmodule
